@@ rtl/core/mcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, message codes and note folding for the chord memory.
// ----------------------------------------------------------------------------
package mcm_pkg;

    typedef enum logic [1:0] {
        KIND_NOTE_ON    = 2'd0,
        KIND_NOTE_OFF   = 2'd1,
        KIND_AFTERTOUCH = 2'd2,
        KIND_CLEAR      = 2'd3
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_PLAY = 1'b1
    } t_state;

    localparam logic [7:0] STATUS_NOTE_ON    = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF   = 8'h80;
    localparam logic [7:0] STATUS_AFTERTOUCH = 8'ha0;
    localparam logic [6:0] NOTE_MAX          = 7'd127;
    localparam logic [3:0] OCTAVE            = 4'd12;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic idx_inc;
        logic record;
        logic clear;
        logic emit_pass;
        logic emit_chord;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic excluded;
        logic count_zero;
        logic idx_last;
    } t_stat;

    function automatic logic [7:0] status_of(input t_kind kind, input logic [3:0] chan);
        logic [7:0] base;
        unique case (kind)
            KIND_NOTE_ON:  base = STATUS_NOTE_ON;
            KIND_NOTE_OFF: base = STATUS_NOTE_OFF;
            default:       base = STATUS_AFTERTOUCH;
        endcase
        return base | {4'd0, chan};
    endfunction

    // remainder by twelve of a 7-bit value, reciprocal multiply and one correction
    function automatic logic [3:0] mod12(input logic [6:0] x);
        logic [12:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 13'(x) * 13'd43;
        q = p[12:9];
        r = x - (7'({q, 3'b000}) + 7'({q, 2'b00}));
        if (r >= 7'(OCTAVE)) begin
            r = r - 7'(OCTAVE);
        end
        return r[3:0];
    endfunction

    // fold a signed note offset result into 0..127 by octaves
    function automatic logic [6:0] fold_note(input logic signed [8:0] s);
        logic [6:0] x;
        logic [3:0] r;
        logic [3:0] up;
        logic [6:0] res;
        if (s < 0) begin
            x  = 7'(-s);
            r  = mod12(x);
            up = (r == 4'd0) ? 4'd0 : OCTAVE - r;
            res = {3'd0, up};
        end else if (s > 9'sd127) begin
            x  = 7'(s - 9'sd127);
            r  = mod12(x);
            up = (r == 4'd0) ? 4'd0 : OCTAVE - r;
            res = NOTE_MAX - {3'd0, up};
        end else begin
            x  = s[6:0];
            r  = 4'd0;
            up = 4'd0;
            res = x;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/mcm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_ctrl
// Sequencer: decodes each accepted event and steps chord playback.
// ----------------------------------------------------------------------------
module mcm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_kind,
    input  logic          i_editing,
    input  mcm_pkg::t_stat i_stat,
    output mcm_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import mcm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    t_kind  kind;

    assign kind   = t_kind'(i_kind);
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state == S_PLAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && kind != KIND_CLEAR && !i_stat.excluded && !i_editing
                    && !i_stat.count_zero) begin
                    n_state = S_PLAY;
                end
            end
            S_PLAY: begin
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (kind == KIND_CLEAR) begin
                        o_cmd.clear = !i_editing;
                    end else if (i_stat.excluded) begin
                        o_cmd.emit_pass = 1'b1;
                    end else if (i_editing) begin
                        o_cmd.emit_pass = 1'b1;
                        o_cmd.record    = (kind == KIND_NOTE_ON);
                    end else if (i_stat.count_zero) begin
                        o_cmd.emit_pass = 1'b1;
                    end
                end
            end
            S_PLAY: begin
                o_cmd.emit_chord = 1'b1;
                o_cmd.idx_inc    = !i_stat.idx_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/mcm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_datapath
// Chord store, playback index, note transpose and result register.
// ----------------------------------------------------------------------------
module mcm_datapath #(
    parameter int MAX_CHORD_NOTES = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcm_pkg::t_cmd  i_cmd,
    input  logic [4:0]    i_filter,
    input  logic [1:0]    i_kind,
    input  logic [3:0]    i_channel,
    input  logic [6:0]    i_note,
    input  logic [6:0]    i_velocity,
    output mcm_pkg::t_stat o_stat,
    output logic          o_valid,
    output logic [7:0]    o_status_byte,
    output logic [6:0]    o_out_note,
    output logic [6:0]    o_out_velocity,
    output logic          o_last
);
    import mcm_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHORD_NOTES);
    localparam int CNT_W = $clog2(MAX_CHORD_NOTES + 1);

    logic [6:0]       r_notes [MAX_CHORD_NOTES];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_status;
    logic [6:0]       r_note;
    logic [6:0]       r_vel;

    logic             r_valid;
    logic [7:0]       r_out_status;
    logic [6:0]       r_out_note;
    logic [6:0]       r_out_vel;
    logic             r_out_last;

    logic [7:0]        in_status;
    logic signed [8:0] offset_sum;
    logic [6:0]        chord_note;

    assign in_status = status_of(t_kind'(i_kind), i_channel);

    assign o_stat.excluded   = (i_filter != 5'd0) && (i_filter != ({1'b0, i_channel} + 5'd1));
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign offset_sum = $signed({2'b00, r_note}) + $signed({2'b00, r_notes[r_idx]})
                        - $signed({2'b00, r_notes[0]});
    assign chord_note = fold_note(offset_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.record && (r_count < CNT_W'(MAX_CHORD_NOTES))) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            if (r_count < CNT_W'(MAX_CHORD_NOTES)) begin
                r_notes[r_count[IDX_W-1:0]] <= i_note;
            end else begin
                for (int i = 1; i < MAX_CHORD_NOTES - 1; i++) begin
                    r_notes[i] <= r_notes[i+1];
                end
                r_notes[MAX_CHORD_NOTES-1] <= i_note;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= in_status;
            r_note   <= i_note;
            r_vel    <= i_velocity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_pass || i_cmd.emit_chord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pass) begin
            r_out_status <= in_status;
            r_out_note   <= i_note;
            r_out_vel    <= i_velocity;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_chord) begin
            r_out_status <= r_status;
            r_out_note   <= chord_note;
            r_out_vel    <= r_vel;
            r_out_last   <= o_stat.idx_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_status_byte  = r_out_status;
    assign o_out_note     = r_out_note;
    assign o_out_velocity = r_out_vel;
    assign o_last         = r_out_last;

endmodule

@@ rtl/core/midi_chord_memory.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_chord_memory
// Records note-on events into a chord store and replays incoming notes as
// the stored chord, transposed and folded into the MIDI note range.
// ----------------------------------------------------------------------------
// channel   handshake                         payload
// event in  start / busy                      i_kind i_channel i_note i_velocity i_editing
// result    o_valid strobe, one cycle          o_status_byte o_out_note o_out_velocity o_last
// config    psel penable pwrite / pready      paddr pwdata prdata (channel_filter)
//
// pass-through and record events: busy stays low, result in the next cycle; clear gives none
// chord playback: first result after the state and result registers, then one per cycle,
// one per stored note (up to MAX_CHORD_NOTES), busy high; set by the single transpose unit
// reset clears the note count and filter; store contents need no clearing
// results cannot be stalled: each stands on the ports for one cycle only
// ----------------------------------------------------------------------------
module midi_chord_memory #(
    parameter int MAX_CHORD_NOTES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic        i_editing,
    output logic        o_valid,
    output logic [7:0]  o_status_byte,
    output logic [6:0]  o_out_note,
    output logic [6:0]  o_out_velocity,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcm_pkg::*;

    logic [4:0] r_filter;
    t_cmd       cmd;
    t_stat      stat;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr == 3'd0) || (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {27'd0, r_filter} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= 5'd0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_filter <= pwdata[4:0];
        end
    end

    mcm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_kind    (i_kind),
        .i_editing (i_editing),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    mcm_datapath #(
        .MAX_CHORD_NOTES (MAX_CHORD_NOTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_filter       (r_filter),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status_byte  (o_status_byte),
        .o_out_note     (o_out_note),
        .o_out_velocity (o_out_velocity),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    // every playback cycle produces a result
    a_play_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("playback cycle without result");

    // the final result of an event leaves the block free
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy after final result");

    // results before the final one belong to an ongoing playback
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result outside playback");

    // a clear event never produces a result
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (t_kind'(i_kind) == KIND_CLEAR) |=> !o_valid)
        else $error("clear event produced a result");
`endif

endmodule

@@ bench/midi_chord_memory_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_chord_memory_tb
// Self-checking bench for the chord memory. Drives note, aftertouch and
// clear events under several channel filter settings and sender gap
// patterns. Every result message is compared field by field against a
// predicted chord store that records notes while editing and replays
// folded chords outside editing.
// ----------------------------------------------------------------------------
module midi_chord_memory_tb;
    import mcm_pkg::*;

    localparam int         CHORD_DEPTH         = 14;
    localparam int         WATCHDOG_LIMIT      = 3000;
    localparam int         DRAIN_CYCLES        = 4;
    localparam logic [2:0] ADDR_CHANNEL_FILTER = 3'd0;

    typedef struct {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        logic       last;
    } t_midi_msg;

    class chord_replay_board;
        logic [6:0] chord[CHORD_DEPTH];
        int         count;
        logic [4:0] filter;
        t_midi_msg  pending_msgs[$];
        int         errors;

        function new();
            count  = 0;
            filter = 5'd0;
            errors = 0;
        endfunction

        task report(input string what, input int got, input int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        function void push_msg(input logic [7:0] status, input logic [6:0] note,
                               input logic [6:0] vel, input logic last);
            t_midi_msg m;
            m.status = status;
            m.note   = note;
            m.vel    = vel;
            m.last   = last;
            pending_msgs.push_back(m);
        endfunction

        function void record(input logic [6:0] note);
            if (count < CHORD_DEPTH) begin
                chord[count] = note;
                count++;
            end else begin
                for (int i = 1; i + 1 < CHORD_DEPTH; i++) chord[i] = chord[i + 1];
                chord[CHORD_DEPTH - 1] = note;
            end
        endfunction

        function void note_event(input t_kind kind, input logic [3:0] chan,
                                 input logic [6:0] note, input logic [6:0] vel,
                                 input logic editing);
            logic [7:0] status;
            logic       excluded;
            int         n;
            if (kind == KIND_CLEAR) begin
                if (!editing) count = 0;
                return;
            end
            case (kind)
                KIND_NOTE_ON:  status = STATUS_NOTE_ON;
                KIND_NOTE_OFF: status = STATUS_NOTE_OFF;
                default:       status = STATUS_AFTERTOUCH;
            endcase
            status   = status | {4'd0, chan};
            excluded = (filter != 5'd0) && (filter != {1'b0, chan} + 5'd1);
            if (excluded || editing || count == 0) begin
                if (!excluded && editing && kind == KIND_NOTE_ON) record(note);
                push_msg(status, note, vel, 1'b1);
            end else begin
                for (int i = 0; i < count; i++) begin
                    n = int'(note) + int'(chord[i]) - int'(chord[0]);
                    while (n < 0) n += 12;
                    while (n > 127) n -= 12;
                    push_msg(status, 7'(n), vel, i == count - 1);
                end
            end
        endfunction

        task check_message(input logic [7:0] status, input logic [6:0] note,
                           input logic [6:0] vel, input logic last);
            t_midi_msg m;
            if (pending_msgs.size() == 0) begin
                report("unexpected transaction, status", status, 0);
                return;
            end
            m = pending_msgs.pop_front();
            if (status !== m.status) report("status_byte", status, m.status);
            if (note !== m.note) report("out_note", note, m.note);
            if (vel !== m.vel) report("out_velocity", vel, m.vel);
            if (last !== m.last) report("last", last, m.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [3:0]  i_channel;
    logic [6:0]  i_note;
    logic [6:0]  i_velocity;
    logic        i_editing;
    logic        o_valid;
    logic [7:0]  o_status_byte;
    logic [6:0]  o_out_note;
    logic [6:0]  o_out_velocity;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chord_replay_board sb = new();
    logic [4:0]        cur_filter;
    int                stall_cycles;

    midi_chord_memory #(
        .MAX_CHORD_NOTES(CHORD_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_note        (i_note),
        .i_velocity    (i_velocity),
        .i_editing     (i_editing),
        .o_valid       (o_valid),
        .o_status_byte (o_status_byte),
        .o_out_note    (o_out_note),
        .o_out_velocity(o_out_velocity),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_message(o_status_byte, o_out_note, o_out_velocity, o_last);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_filter(input logic [4:0] value);
        @(negedge i_clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = ADDR_CHANNEL_FILTER;
        pwdata = {27'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cur_filter = value;
        sb.filter  = value;
    endtask

    task automatic send_event(input t_kind kind, input logic [3:0] chan,
                              input logic [6:0] note, input logic [6:0] vel,
                              input logic editing, input int gap_pct);
        if ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_kind     = kind;
        i_channel  = chan;
        i_note     = note;
        i_velocity = vel;
        i_editing  = editing;
        do @(posedge i_clk); while (busy);
        sb.note_event(kind, chan, note, vel, editing);
    endtask

    // idle between phases; clears leave no result to wait on
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_channel();
        if (cur_filter >= 5'd1 && cur_filter <= 5'd16 && $urandom_range(3) != 0) begin
            return 4'(cur_filter - 5'd1);
        end
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [6:0] note_near(input logic [6:0] root, input int spread);
        int v;
        v = int'(root) + int'($urandom_range(2 * spread)) - spread;
        return 7'(((v % 128) + 128) % 128);
    endfunction

    task automatic directed_events();
        logic [6:0] rec_notes[15] = '{7'd60, 7'd127, 7'd0, 7'd64, 7'd67, 7'd71, 7'd48,
                                     7'd36, 7'd100, 7'd5, 7'd90, 7'd72, 7'd84, 7'd30,
                                     7'd115};
        send_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0, 1'b0, 0);
        send_event(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd127, 1'b0, 0);
        send_event(KIND_AFTERTOUCH, 4'd5, 7'd64, 7'd1, 1'b1, 0);
        send_event(KIND_NOTE_OFF, 4'd10, 7'd3, 7'd64, 1'b1, 0);
        // fifteen notes overflow the store and exercise the shift
        foreach (rec_notes[i]) begin
            send_event(KIND_NOTE_ON, 4'(i), rec_notes[i], 7'(8 * i), 1'b1, 0);
        end
        send_event(KIND_NOTE_ON, 4'd15, 7'd0, 7'd127, 1'b0, 0);
        send_event(KIND_NOTE_OFF, 4'd0, 7'd127, 7'd0, 1'b0, 0);
        send_event(KIND_AFTERTOUCH, 4'd7, 7'd60, 7'd85, 1'b0, 0);
        send_event(KIND_CLEAR, 4'd2, 7'd0, 7'd0, 1'b1, 0);
        send_event(KIND_NOTE_ON, 4'd3, 7'd20, 7'd42, 1'b0, 0);
        send_event(KIND_CLEAR, 4'd9, 7'd127, 7'd127, 1'b0, 0);
        send_event(KIND_NOTE_ON, 4'd12, 7'd42, 7'd99, 1'b0, 0);
    endtask

    task automatic random_phase(input int gap_pct, input int n_items);
        int         sent;
        int         chord_len;
        int         plays;
        int         spread;
        logic [6:0] root;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                send_event(KIND_CLEAR, pick_channel(), 7'($urandom_range(127)),
                           7'($urandom_range(127)), 1'b0, gap_pct);
                chord_len = ($urandom_range(4) == 0) ? $urandom_range(15, 20)
                                                     : $urandom_range(1, 14);
                root   = 7'($urandom_range(127));
                spread = $urandom_range(1) ? 24 : 127;
                for (int i = 0; i < chord_len; i++) begin
                    send_event(KIND_NOTE_ON, pick_channel(), note_near(root, spread),
                               7'($urandom_range(127)), 1'b1, gap_pct);
                end
                plays = $urandom_range(1, 5);
                for (int i = 0; i < plays; i++) begin
                    send_event(t_kind'($urandom_range(2)), pick_channel(),
                               7'($urandom_range(127)), 7'($urandom_range(127)),
                               1'b0, gap_pct);
                end
                sent += 1 + chord_len + plays;
            end else begin
                send_event(t_kind'($urandom_range(3)), pick_channel(),
                           7'($urandom_range(127)), 7'($urandom_range(127)),
                           1'($urandom_range(1)), gap_pct);
                sent++;
            end
        end
        drain_block();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_NOTE_ON;
        i_channel    = 4'd0;
        i_note       = 7'd0;
        i_velocity   = 7'd0;
        i_editing    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ADDR_CHANNEL_FILTER;
        pwdata       = 32'd0;
        cur_filter   = 5'd0;
        stall_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_filter(5'd0);
        directed_events();
        drain_block();

        random_phase(0, 55);
        write_filter(5'd16);
        random_phase(86, 55);
        write_filter(5'd31);
        random_phase(0, 55);
        write_filter(5'($urandom_range(1, 15)));
        random_phase(36, 55);

        if (sb.pending_msgs.size() != 0) begin
            sb.report("transactions never seen", 0, sb.pending_msgs.size());
        end
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mcm_pkg.sv
rtl/core/mcm_ctrl.sv
rtl/core/mcm_datapath.sv
rtl/core/midi_chord_memory.sv
bench/midi_chord_memory_tb.sv
